@@ hdl/slpg_pkg.sv @@
// Shared types, constants and the breathing table for the status-LED duty generator.
// Depends on nothing; imported by the core and by its checker.
package slpg_pkg;

  // Default width of the free-running tick counter.
  localparam int unsigned CounterWidthDefault = 32;

  // Operation codes of an input word.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // LED modes, as carried on the result port.
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_BREATH  = 2'd1,
    MODE_CONN    = 2'd2,
    MODE_FLASH   = 2'd3
  } mode_t;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] CFG_ATTACK_GAIN    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_RELEASE_GAIN   = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_SNAP_THRESHOLD = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  ATTACK_GAIN_RST    = 8'd115;
  localparam logic [7:0]  RELEASE_GAIN_RST   = 8'd51;
  localparam logic [15:0] SNAP_THRESHOLD_RST = 16'd131;

  // Breathing table: ten steps, indexed by the modulo-ten phase kept beside the counter.
  localparam int unsigned SineLen = 10;
  localparam int unsigned PhaseWidth = $clog2(SineLen);
  localparam logic [PhaseWidth-1:0] PHASE_LAST = PhaseWidth'(SineLen - 1);

  // Fixed duties.
  localparam logic [7:0] DUTY_CONN_SELECT = 8'd25;
  localparam logic [7:0] DUTY_FLASH_ON    = 8'd127;
  localparam logic [7:0] DUTY_ZERO        = 8'd0;

  // Connected-mode level to duty map: duty = (CONN_OFFSET + CONN_SCALE * s) >> 17.
  localparam int unsigned ConnSumWidth = 25;
  localparam logic [ConnSumWidth-1:0] CONN_OFFSET = 25'd3342336;
  localparam logic [8:0]              CONN_SCALE  = 9'd459;
  localparam int unsigned             ConnShift   = 17;

  // Where the second stage takes its duty from.
  typedef enum logic [1:0] {
    SRC_CONST  = 2'd0,
    SRC_CONN   = 2'd1,
    SRC_REPEAT = 2'd2
  } duty_src_t;

  function automatic logic [7:0] sine_duty(input logic [PhaseWidth-1:0] idx);
    logic [7:0] d;
    case (idx)
      4'd0:    d = 8'd38;
      4'd1:    d = 8'd60;
      4'd2:    d = 8'd74;
      4'd3:    d = 8'd74;
      4'd4:    d = 8'd60;
      4'd5:    d = 8'd38;
      4'd6:    d = 8'd15;
      4'd7:    d = 8'd1;
      4'd8:    d = 8'd1;
      4'd9:    d = 8'd15;
      default: d = 8'd0;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/status_led_pattern_generator_core.sv @@
// Status-LED duty generator core: tick/select words in, one duty word out per word.
// Depends on slpg_pkg for modes, register indexes, reset values and the breathing table.
//
// An accepted word passes the stage A register, then stage B, then the result register.
// Throughput: one word per cycle while out_ready holds; the state update sits in the first
// stage, the duty map in the second; a stage passes a word on whenever the next one moves.
// Reset (rst_n low, synchronous): pipeline empty, mode off, counter, level and last duty
// zero, configuration registers at their documented defaults.
module status_led_pattern_generator_core
  import slpg_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = CounterWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_operation,
  input  logic [1:0]               in_new_mode,
  input  logic [15:0]              in_target_level,
  input  logic                     in_haptics_enabled,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_led_duty,
  output logic [1:0]               out_current_mode,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [15:0]              cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; an index past the last
  // register is simply ignored.
  // ---------------------------------------------------------------------------
  logic [7:0]  attack_gain_r;
  logic [7:0]  release_gain_r;
  logic [15:0] snap_threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_gain_r    <= ATTACK_GAIN_RST;
      release_gain_r   <= RELEASE_GAIN_RST;
      snap_threshold_r <= SNAP_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ATTACK_GAIN:    attack_gain_r    <= cfg_data[7:0];
        CFG_RELEASE_GAIN:   release_gain_r   <= cfg_data[7:0];
        CFG_SNAP_THRESHOLD: snap_threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves when it holds a word and the stage
  // after it is empty or is itself moving on, so the input keeps flowing while
  // a finished word waits on the result port.
  // ---------------------------------------------------------------------------
  logic a_valid_r;
  logic b_valid_r;
  logic out_valid_r;
  logic a_adv;
  logic b_adv;

  assign b_adv    = b_valid_r && (!out_valid_r || out_ready);
  assign a_adv    = a_valid_r && (!b_valid_r || b_adv);
  assign in_ready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready)               a_valid_r   <= in_valid;
      if (!b_valid_r || b_adv)    b_valid_r   <= a_valid_r;
      if (!out_valid_r || out_ready) out_valid_r <= b_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register (stage A payload).
  // ---------------------------------------------------------------------------
  logic        a_op_r;
  logic [1:0]  a_new_mode_r;
  logic [15:0] a_target_r;
  logic        a_enabled_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_op_r       <= in_operation;
      a_new_mode_r <= in_new_mode;
      a_target_r   <= in_target_level;
      a_enabled_r  <= in_haptics_enabled;
    end
  end

  // ---------------------------------------------------------------------------
  // Block state. The counter keeps a modulo-ten phase beside it so that the
  // breathing table needs no divider; the phase returns to zero whenever the
  // counter itself does, including when it wraps.
  // ---------------------------------------------------------------------------
  mode_t                    mode_r,    mode_nxt;
  logic [COUNTER_WIDTH-1:0] counter_r, counter_nxt;
  logic [PhaseWidth-1:0]    phase_r,   phase_nxt;
  logic [15:0]              level_r,   level_nxt;
  logic [7:0]               last_duty_r;

  // Stage A working values.
  logic [COUNTER_WIDTH-1:0] counter_inc;
  logic [PhaseWidth-1:0]    phase_inc;
  logic [15:0]              target_eff;
  logic [15:0]              level_diff;
  logic [7:0]               gain_sel;
  logic [23:0]              gain_prod;
  logic [15:0]              level_step;
  logic [15:0]              level_moved;
  duty_src_t                src_nxt;
  logic [7:0]               const_duty_nxt;

  assign counter_inc = counter_r + COUNTER_WIDTH'(1);
  assign phase_inc   = (counter_inc == '0)    ? '0 :
                       (phase_r == PHASE_LAST) ? '0 :
                       phase_r + PhaseWidth'(1);

  // Envelope follower: one gain multiply on the distance to the target, the
  // attack gain when rising and the release gain when falling or level.
  assign target_eff  = a_enabled_r ? a_target_r : 16'd0;
  assign level_diff  = (target_eff > level_r) ? (target_eff - level_r) : (level_r - target_eff);
  assign gain_sel    = (target_eff > level_r) ? attack_gain_r : release_gain_r;
  assign gain_prod   = level_diff * gain_sel;
  assign level_step  = gain_prod[23:8];
  assign level_moved = (target_eff > level_r) ? (level_r + level_step) : (level_r - level_step);

  always_comb begin
    mode_nxt       = mode_r;
    counter_nxt    = counter_r;
    phase_nxt      = phase_r;
    level_nxt      = level_r;
    src_nxt        = SRC_REPEAT;
    const_duty_nxt = DUTY_ZERO;
    if (a_op_r == OP_TICK) begin
      counter_nxt = counter_inc;
      phase_nxt   = phase_inc;
      src_nxt     = SRC_CONST;
      case (mode_r)
        MODE_BREATH: const_duty_nxt = sine_duty(phase_inc);
        MODE_CONN: begin
          // Small levels are snapped to zero so the LED settles cleanly.
          level_nxt = (level_moved < snap_threshold_r) ? 16'd0 : level_moved;
          src_nxt   = SRC_CONN;
        end
        MODE_FLASH:  const_duty_nxt = counter_inc[1] ? DUTY_ZERO : DUTY_FLASH_ON;
        default:     const_duty_nxt = DUTY_ZERO;
      endcase
    end else begin
      case (a_new_mode_r)
        MODE_BREATH, MODE_FLASH: begin
          mode_nxt    = mode_t'(a_new_mode_r);
          counter_nxt = '0;
          phase_nxt   = '0;
        end
        MODE_CONN: begin
          mode_nxt       = MODE_CONN;
          src_nxt        = SRC_CONST;
          const_duty_nxt = DUTY_CONN_SELECT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_OFF;
      counter_r <= '0;
      phase_r   <= '0;
      level_r   <= '0;
    end else if (a_adv) begin
      mode_r    <= mode_nxt;
      counter_r <= counter_nxt;
      phase_r   <= phase_nxt;
      level_r   <= level_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: the word carries a snapshot of the new level, so the level map
  // does not see updates made by the word behind it.
  // ---------------------------------------------------------------------------
  duty_src_t   b_src_r;
  logic [7:0]  b_const_duty_r;
  logic [15:0] b_level_r;
  mode_t       b_mode_r;

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_src_r        <= src_nxt;
      b_const_duty_r <= const_duty_nxt;
      b_level_r      <= level_nxt;
      b_mode_r       <= mode_nxt;
    end
  end

  // Level to duty: a constant scale and offset, giving 25 to 254.
  logic [ConnSumWidth-1:0] conn_sum;
  logic [7:0]              conn_duty;
  logic [7:0]              duty_nxt;

  assign conn_sum  = CONN_OFFSET + ConnSumWidth'(b_level_r) * ConnSumWidth'(CONN_SCALE);
  assign conn_duty = conn_sum[ConnShift +: 8];

  // A repeated duty reads last_duty_r, which the word ahead has already written
  // by the time this word reaches stage B.
  always_comb begin
    case (b_src_r)
      SRC_CONST:  duty_nxt = b_const_duty_r;
      SRC_CONN:   duty_nxt = conn_duty;
      SRC_REPEAT: duty_nxt = last_duty_r;
      default:    duty_nxt = DUTY_ZERO;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic [7:0] out_duty_r;
  mode_t      out_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_duty_r <= DUTY_ZERO;
    end else if (b_adv) begin
      last_duty_r <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_duty_r <= duty_nxt;
      out_mode_r <= b_mode_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_duty     = out_duty_r;
  assign out_current_mode = out_mode_r;

endmodule

@@ hdl/slpg_checker.sv @@
// Port-level checker for the status-LED duty generator core, with its bind.
// Depends on slpg_pkg and on the port list of status_led_pattern_generator_core.
module slpg_checker
  import slpg_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_led_duty,
  input logic [1:0] out_current_mode
);

  // A held result word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_duty)
      && $stable(out_current_mode))
    else $error("result word changed while stalled");

  // Nothing but ticks and ignored selects can happen before a mode is chosen.
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_current_mode == MODE_OFF |-> out_led_duty == DUTY_ZERO)
    else $error("nonzero duty while off");

  // Connected mode always maps into the 10% to 100% band.
  a_conn_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_current_mode == MODE_CONN |->
      out_led_duty >= 8'd25 && out_led_duty <= 8'd254)
    else $error("connected duty out of range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind status_led_pattern_generator_core slpg_checker u_slpg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_led_duty     (out_led_duty),
  .out_current_mode (out_current_mode)
);
